### rtl/dtl_pkg.sv
// Shared types, constants and the tanh table for the dense tanh layer.
package dtl_pkg;

  localparam int ROWS_DEF      = 32;
  localparam int COLS_DEF      = 64;
  localparam int FRAC_BITS_DEF = 12;

  localparam int TAB_LEN = 257;

  typedef enum logic [2:0] {
    CMD_LOAD_W  = 3'd0,
    CMD_LOAD_X  = 3'd1,
    CMD_LOAD_D  = 3'd2,
    CMD_FWD     = 3'd3,
    CMD_BWD     = 3'd4
  } cmd_e;

  localparam logic KIND_ACT  = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

  typedef logic [30:0] tanh_tab_t [TAB_LEN];

  // Builds tanh(k/32) in Q30 with the addition formula, evaluated at elaboration.
  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t   t;
    logic [63:0] prev;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] nv;
    logic [63:0] dividend;
    logic [63:0] quo;
    logic [63:0] rem;
    t[0] = '0;
    prev = '0;
    for (int k = 1; k < TAB_LEN; k++) begin
      num = prev + 64'd33543514;
      den = (64'd1 << 30) + ((prev * 64'd33543514) >> 30);
      // Restoring long division of the shifted numerator, truncating.
      dividend = num << 30;
      quo      = '0;
      rem      = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], dividend[b]};
        if (rem >= den) begin
          rem    = rem - den;
          quo[b] = 1'b1;
        end
      end
      nv = quo;
      if (nv < prev) nv = prev;
      if (nv > (64'd1 << 30)) nv = 64'd1 << 30;
      t[k] = nv[30:0];
      prev = nv;
    end
    return t;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

  function automatic logic signed [15:0] sat16(input logic signed [55:0] v);
    if (v > 56'sd32767) return 16'sh7fff;
    if (v < -56'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

### rtl/dense_tanh_layer_fwd_bwd.sv
// Dense tanh layer with forward and backward passes on one shared multiplier.
//
// Loads of a weight, input or delta word give no result. A forward
// run streams every row through the two-stage multiply-accumulate pipeline, one product
// a cycle, waits in ST_FWAIT for the pipeline to drain, then runs the tanh interpolation
// through the same multiplier in states ST_TA to ST_TD; ROWS activation words are each
// shown for one cycle with result_valid_o. A backward run forms the scaled delta in
// states ST_B0 to ST_B4 with two multiplies, then one gradient word per cycle follows
// for every column. Results cannot be held off by the receiver; busy_o stays high until
// the last word of a run is registered, and that word shows in the first idle cycle.
module dense_tanh_layer_fwd_bwd #(
  parameter int ROWS      = dtl_pkg::ROWS_DEF,
  parameter int COLS      = dtl_pkg::COLS_DEF,
  parameter int FRAC_BITS = dtl_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         command_i,
  input  logic [4:0]         row_i,
  input  logic [5:0]         col_i,
  input  logic signed [15:0] value_i,
  output logic               result_valid_o,
  output logic               kind_o,
  output logic [4:0]         out_row_o,
  output logic [5:0]         out_col_o,
  output logic signed [15:0] result_value_o,
  output logic               last_o
);

  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int WDEP  = ROWS * COLS;
  localparam int WAW   = (WDEP > 1) ? $clog2(WDEP) : 1;
  localparam int SH    = 2 * FRAC_BITS - 5;
  localparam int ACC_W = 33 + CW;
  localparam logic [ACC_W-1:0] CAP = ACC_W'(8) << (2 * FRAC_BITS);
  localparam logic signed [31:0] ONE2F = 32'sd1 <<< (2 * FRAC_BITS);
  localparam logic [30:0] HALF_Y = 31'd1 << (29 - FRAC_BITS);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FMAC, ST_FWAIT, ST_TA, ST_TB, ST_TC, ST_TD,
    ST_B0, ST_B1, ST_B2, ST_B3, ST_B4, ST_BCOL, ST_BWAIT
  } state_e;

  state_e state_q;

  logic signed [15:0] wmem [WDEP];
  logic signed [15:0] xmem [COLS];
  logic signed [15:0] dmem [ROWS];
  logic signed [15:0] act_q [ROWS];

  logic signed [15:0] w_rd_q, x_rd_q, d_rd_q;
  logic [WAW-1:0]     waddr_q;
  logic [CW-1:0]      ccnt_q;
  logic [RW-1:0]      rcnt_q;
  logic [4:0]         row_q;
  logic               bwd_q;

  logic               s1_v_q, s1_first_q, s1_last_q;
  logic [CW-1:0]      s1_col_q;
  logic               s2_v_q, s2_first_q, s2_last_q;
  logic [CW-1:0]      s2_col_q;

  logic signed [31:0] op_a_q;
  logic signed [23:0] op_b_q;
  logic signed [55:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [15:0] ad_q;

  logic               neg_q;
  logic [8:0]         idx_q;
  logic [SH-1:0]      frac_q;
  logic [30:0]        base_q;

  logic               accept;
  logic               ld_w, ld_x, ld_d;
  logic [WAW-1:0]     ld_addr;
  logic signed [31:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [55:0] prod_d;
  logic [ACC_W-1:0]   mag, capped;
  logic [8:0]         idx_p1;
  logic [30:0]        y, y_rnd;
  logic signed [15:0] tanh_val;
  logic signed [15:0] grad_val;
  logic signed [55:0] ad_rnd;
  logic signed [15:0] a_row;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign ld_w = accept && (command_i == dtl_pkg::CMD_LOAD_W) && (int'(row_i) < ROWS)
                && (int'(col_i) < COLS);
  assign ld_x = accept && (command_i == dtl_pkg::CMD_LOAD_X) && (int'(col_i) < COLS);
  assign ld_d = accept && (command_i == dtl_pkg::CMD_LOAD_D) && (int'(row_i) < ROWS);
  assign ld_addr = WAW'(int'(row_i) * COLS + int'(col_i));

  // The multiplier serves the streaming column pipeline or the operand registers.
  always_comb begin
    if (s1_v_q) begin
      mul_a = bwd_q ? 32'(ad_q) : 32'(w_rd_q);
      mul_b = 24'(x_rd_q);
    end else begin
      mul_a = op_a_q;
      mul_b = op_b_q;
    end
    prod_d = mul_a * mul_b;
  end

  always_comb begin
    mag    = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    capped = (mag > CAP) ? CAP : mag;
    idx_p1 = idx_q + 9'd1;
    y      = base_q + prod_q[SH+30:SH];
    y_rnd  = (y + HALF_Y) >> (30 - FRAC_BITS);
    tanh_val = neg_q ? -16'(y_rnd) : 16'(y_rnd);
    grad_val = dtl_pkg::sat16((prod_q + (56'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    ad_rnd   = (prod_q + (56'sd1 <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
    a_row    = act_q[RW'(row_q)];
  end

  always_ff @(posedge clk_i) begin
    if (ld_w) wmem[ld_addr] <= value_i;
    if (ld_x) xmem[CW'(col_i)] <= value_i;
    if (ld_d) dmem[RW'(row_i)] <= value_i;
    w_rd_q <= wmem[waddr_q];
    x_rd_q <= xmem[ccnt_q];
    d_rd_q <= dmem[RW'(row_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      waddr_q        <= '0;
      ccnt_q         <= '0;
      rcnt_q         <= '0;
      row_q          <= '0;
      bwd_q          <= 1'b0;
      s1_v_q         <= 1'b0;
      s2_v_q         <= 1'b0;
      result_valid_o <= 1'b0;
      for (int i = 0; i < ROWS; i++) act_q[i] <= '0;
    end else begin
      result_valid_o <= 1'b0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= s1_v_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_col_q   <= s1_col_q;
      prod_q     <= prod_d;
      if (s2_v_q && !bwd_q) begin
        acc_q <= (s2_first_q ? '0 : acc_q) + prod_q[ACC_W-1:0];
      end
      if (s2_v_q && bwd_q) begin
        result_valid_o <= 1'b1;
        kind_o         <= dtl_pkg::KIND_GRAD;
        out_row_o      <= row_q;
        out_col_o      <= 6'(s2_col_q);
        result_value_o <= grad_val;
        last_o         <= s2_last_q;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && command_i == dtl_pkg::CMD_FWD) begin
            bwd_q   <= 1'b0;
            waddr_q <= '0;
            ccnt_q  <= '0;
            rcnt_q  <= '0;
            state_q <= ST_FMAC;
          end else if (accept && command_i == dtl_pkg::CMD_BWD && int'(row_i) < ROWS) begin
            bwd_q   <= 1'b1;
            row_q   <= row_i;
            ccnt_q  <= '0;
            state_q <= ST_B0;
          end
        end
        ST_FMAC, ST_BCOL: begin
          s1_v_q     <= 1'b1;
          s1_first_q <= (ccnt_q == '0);
          s1_last_q  <= (int'(ccnt_q) == COLS - 1);
          s1_col_q   <= ccnt_q;
          waddr_q    <= waddr_q + WAW'(1);
          if (int'(ccnt_q) == COLS - 1) begin
            ccnt_q  <= '0;
            state_q <= (state_q == ST_FMAC) ? ST_FWAIT : ST_BWAIT;
          end else begin
            ccnt_q <= ccnt_q + CW'(1);
          end
        end
        ST_FWAIT: begin
          if (s2_v_q && s2_last_q) state_q <= ST_TA;
        end
        ST_TA: begin
          neg_q   <= acc_q[ACC_W-1];
          idx_q   <= capped[SH+8:SH];
          frac_q  <= capped[SH-1:0];
          state_q <= ST_TB;
        end
        ST_TB: begin
          // Past the table end the curve is flat at its last entry.
          if (idx_q == 9'd256) begin
            base_q <= dtl_pkg::TANH_TAB[256];
            op_a_q <= '0;
          end else begin
            base_q <= dtl_pkg::TANH_TAB[idx_q];
            op_a_q <= 32'(dtl_pkg::TANH_TAB[idx_p1] - dtl_pkg::TANH_TAB[idx_q]);
          end
          op_b_q  <= 24'(frac_q);
          state_q <= ST_TC;
        end
        ST_TC: state_q <= ST_TD;
        ST_TD: begin
          act_q[rcnt_q]  <= tanh_val;
          result_valid_o <= 1'b1;
          kind_o         <= dtl_pkg::KIND_ACT;
          out_row_o      <= 5'(rcnt_q);
          out_col_o      <= '0;
          result_value_o <= tanh_val;
          last_o         <= (int'(rcnt_q) == ROWS - 1);
          if (int'(rcnt_q) == ROWS - 1) begin
            state_q <= ST_IDLE;
          end else begin
            rcnt_q  <= rcnt_q + RW'(1);
            state_q <= ST_FMAC;
          end
        end
        ST_B0: begin
          op_a_q  <= 32'(a_row);
          op_b_q  <= 24'(a_row);
          state_q <= ST_B1;
        end
        ST_B1: state_q <= ST_B2;
        ST_B2: begin
          op_a_q  <= ONE2F - prod_q[31:0];
          op_b_q  <= 24'(d_rd_q);
          state_q <= ST_B3;
        end
        ST_B3: state_q <= ST_B4;
        ST_B4: begin
          ad_q    <= dtl_pkg::sat16(ad_rnd);
          state_q <= ST_BCOL;
        end
        ST_BWAIT: begin
          if (s2_v_q && s2_last_q) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/dtl_checker.sv
// Port-level checks for the dense tanh layer, bound to its top level.
module dtl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [2:0]         command_i,
  input logic               result_valid_o,
  input logic               kind_o,
  input logic [5:0]         out_col_o,
  input logic               last_o
);

  a_fwd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && command_i == dtl_pkg::CMD_FWD |=> busy_o)
    else $error("forward run did not raise busy");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o)
    else $error("block went idle before the last word");

  a_act_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == dtl_pkg::KIND_ACT |-> out_col_o == 6'd0)
    else $error("activation word with a column index");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (command_i == dtl_pkg::CMD_LOAD_W ||
    command_i == dtl_pkg::CMD_LOAD_X || command_i == dtl_pkg::CMD_LOAD_D)
    |=> !busy_o && !result_valid_o)
    else $error("load produced activity");

endmodule

bind dense_tanh_layer_fwd_bwd dtl_checker u_dtl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .command_i      (command_i),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .out_col_o      (out_col_o),
  .last_o         (last_o)
);

### verif/dense_tanh_layer_fwd_bwd_tb.sv
// Self-checking testbench for the dense tanh layer with forward and backward passes.
`timescale 1ns / 100ps

module dense_tanh_layer_fwd_bwd_tb;

  localparam int NROW        = 32;
  localparam int NCOL        = 64;
  localparam int CYCLE_LIMIT = 5000000;

  typedef struct packed {
    logic               kind;
    logic [4:0]         row;
    logic [5:0]         col;
    logic signed [15:0] value;
    logic               last;
  } layer_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         command_i = '0;
  logic [4:0]         row_i = '0;
  logic [5:0]         col_i = '0;
  logic signed [15:0] value_i = '0;
  logic               result_valid_o;
  logic               kind_o;
  logic [4:0]         out_row_o;
  logic [5:0]         out_col_o;
  logic signed [15:0] result_value_o;
  logic               last_o;

  dense_tanh_layer_fwd_bwd DUT (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the layer state.
  logic signed [15:0] weight_mem [NROW*NCOL];
  logic signed [15:0] input_mem  [NCOL];
  logic signed [15:0] delta_mem  [NROW];
  logic signed [15:0] act_mem    [NROW];
  logic [63:0]        tanh_lut   [257];

  layer_word_t pending_words[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          allow_gaps = 1'b1;

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Round half up toward +inf, then drop k fraction bits.
  function automatic longint round_down_bits(input longint v, input int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic logic signed [15:0] tanh_q12(input longint s);
    logic [63:0] m;
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] y;
    logic [63:0] r;
    bit          neg;
    neg = s < 0;
    m = neg ? 64'(-s) : 64'(s);
    if (m > (64'd8 << 24)) m = 64'd8 << 24;
    idx = m >> 19;
    if (idx >= 256) begin
      y = tanh_lut[256];
    end else begin
      frac = m & ((64'd1 << 19) - 1);
      y = tanh_lut[idx] + (((tanh_lut[idx+1] - tanh_lut[idx]) * frac) >> 19);
    end
    r = (y + (64'd1 << 17)) >> 18;
    return neg ? -r[15:0] : r[15:0];
  endfunction

  // Updates the shadow state for one accepted word and queues what it causes.
  task automatic predict_word(input logic [2:0] cmd, input logic [4:0] row,
                              input logic [5:0] col, input logic signed [15:0] val);
    longint      acc;
    longint      a;
    longint      g;
    longint      ad;
    layer_word_t w;
    case (cmd)
      dtl_pkg::CMD_LOAD_W: weight_mem[row*NCOL + col] = val;
      dtl_pkg::CMD_LOAD_X: input_mem[col] = val;
      dtl_pkg::CMD_LOAD_D: delta_mem[row] = val;
      dtl_pkg::CMD_FWD: begin
        for (int r = 0; r < NROW; r++) begin
          acc = 0;
          for (int c = 0; c < NCOL; c++)
            acc += longint'(weight_mem[r*NCOL + c]) * longint'(input_mem[c]);
          act_mem[r] = tanh_q12(acc);
          w = '{dtl_pkg::KIND_ACT, 5'(r), 6'd0, act_mem[r], r == NROW - 1};
          pending_words.push_back(w);
        end
      end
      dtl_pkg::CMD_BWD: begin
        a  = act_mem[row];
        g  = (longint'(1) <<< 24) - a * a;
        ad = clamp16(round_down_bits(g * longint'(delta_mem[row]), 24));
        for (int c = 0; c < NCOL; c++) begin
          w = '{dtl_pkg::KIND_GRAD, row, 6'(c),
                clamp16(round_down_bits(ad * longint'(input_mem[c]), 12)), c == NCOL - 1};
          pending_words.push_back(w);
        end
      end
      default: ;
    endcase
  endtask

  // Start stays high between back-to-back words; it drops only for a gap.
  task automatic send_word(input logic [2:0] cmd, input logic [4:0] row,
                           input logic [5:0] col, input logic signed [15:0] val);
    if (allow_gaps && $urandom_range(99) < 7) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    command_i <= cmd;
    row_i     <= row;
    col_i     <= col;
    value_i   <= val;
    do @(posedge clk_i); while (busy_o);
    predict_word(cmd, row, col, val);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
      default: return 16'($signed($urandom_range(2047)) - 1024);
    endcase
  endfunction

  always @(posedge clk_i) begin
    layer_word_t w;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_ni && result_valid_o) begin
      if (pending_words.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        w = pending_words.pop_front();
        if (kind_o !== w.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", kind_o, w.kind));
        if (out_row_o !== w.row)
          report_mismatch($sformatf("row %0d, expected %0d", out_row_o, w.row));
        if (out_col_o !== w.col)
          report_mismatch($sformatf("col %0d, expected %0d", out_col_o, w.col));
        if (result_value_o !== w.value)
          report_mismatch($sformatf("value %0d, expected %0d (row %0d col %0d)",
                                    result_value_o, w.value, w.row, w.col));
        if (last_o !== w.last)
          report_mismatch($sformatf("last %0d, expected %0d", last_o, w.last));
      end
    end
  end

  // Every store entry is written before any run reads it.
  task automatic test_fill_stores();
    for (int i = 0; i < NROW*NCOL; i++)
      send_word(dtl_pkg::CMD_LOAD_W, 5'(i / NCOL), 6'(i % NCOL), pick_value());
    for (int c = 0; c < NCOL; c++)
      send_word(dtl_pkg::CMD_LOAD_X, 5'($urandom), 6'(c), pick_value());
    for (int r = 0; r < NROW; r++)
      send_word(dtl_pkg::CMD_LOAD_D, 5'(r), 6'($urandom), pick_value());
  endtask

  // With no forward run yet the activations are zero, so the derivative is one.
  task automatic test_backward_first();
    send_word(dtl_pkg::CMD_BWD, 5'd0, 6'd0, 16'sd0);
    send_word(dtl_pkg::CMD_BWD, 5'd31, 6'd63, 16'sh7fff);
  endtask

  task automatic test_extremes();
    send_word(dtl_pkg::CMD_LOAD_W, 5'd0, 6'd0, 16'sh7fff);
    send_word(dtl_pkg::CMD_LOAD_X, 5'd0, 6'd0, 16'sh7fff);
    send_word(dtl_pkg::CMD_LOAD_W, 5'd31, 6'd63, 16'sh8000);
    send_word(dtl_pkg::CMD_LOAD_X, 5'd31, 6'd63, 16'sh8000);
    send_word(dtl_pkg::CMD_LOAD_D, 5'd0, 6'd0, 16'sh8000);
    send_word(dtl_pkg::CMD_LOAD_D, 5'd31, 6'd63, 16'sh7fff);
    send_word(dtl_pkg::CMD_LOAD_D, 5'd5, 6'd0, 16'sd0);
    send_word(dtl_pkg::CMD_FWD, 5'd0, 6'd0, 16'sd0);
    send_word(dtl_pkg::CMD_BWD, 5'd0, 6'd0, 16'sd0);
    send_word(dtl_pkg::CMD_BWD, 5'd31, 6'd0, 16'sd0);
    send_word(dtl_pkg::CMD_BWD, 5'd5, 6'd0, 16'sd0);
    send_word(3'd5, 5'd1, 6'd1, 16'sd1);
    send_word(3'd6, 5'd2, 6'd2, 16'sh7fff);
    send_word(3'd7, 5'd31, 6'd63, 16'sh8000);
  endtask

  // Mostly loads with runs mixed in; forward runs are kept rare because they are long.
  task automatic test_random_mix();
    int          pick;
    logic [2:0]  cmd;
    for (int n = 0; n < 290; n++) begin
      allow_gaps = !(n >= 60 && n < 160);
      if (n == 200) drain_results();
      pick = $urandom_range(99);
      if (pick < 6)       cmd = dtl_pkg::CMD_FWD;
      else if (pick < 22) cmd = dtl_pkg::CMD_BWD;
      else if (pick < 26) cmd = 3'($urandom_range(5, 7));
      else if (pick < 55) cmd = dtl_pkg::CMD_LOAD_W;
      else if (pick < 80) cmd = dtl_pkg::CMD_LOAD_X;
      else                cmd = dtl_pkg::CMD_LOAD_D;
      send_word(cmd, 5'($urandom), 6'($urandom), pick_value());
    end
    allow_gaps = 1'b1;
  endtask

  initial begin
    logic [63:0] prev;
    logic [63:0] nv;
    // Table of tanh(k/32) in Q30 from the addition formula.
    tanh_lut[0] = '0;
    prev = '0;
    for (int k = 1; k < 257; k++) begin
      nv = ((prev + 64'd33543514) << 30) / ((64'd1 << 30) + ((prev * 64'd33543514) >> 30));
      if (nv < prev) nv = prev;
      if (nv > (64'd1 << 30)) nv = 64'd1 << 30;
      tanh_lut[k] = nv;
      prev = nv;
    end
    for (int r = 0; r < NROW; r++) act_mem[r] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_stores();
    test_backward_first();
    test_extremes();
    test_random_mix();

    drain_results();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
